### rtl/chlg_pkg.sv
`default_nettype none
package chlg_pkg;

    // width of the cumulative time counters
    localparam int TIME_BITS = 48;
    // deltas are truncated to this width before the load math
    localparam int DELTA_BITS = 32;
    // percent scale and quotient width (load is 0..100)
    localparam int LOAD_SCALE = 100;
    localparam int LOAD_BITS  = 7;
    // numerator 100 * delta fits in delta width plus quotient width
    localparam int NUM_BITS   = DELTA_BITS + LOAD_BITS;
    // lane step counter: one multiply step then one step per quotient bit
    localparam int LANE_LAST  = LOAD_BITS + 1;
    localparam int CNT_BITS   = $clog2(LANE_LAST + 1);

    // event selectors
    localparam logic [2:0] FN_SAMPLE  = 3'd0;
    localparam logic [2:0] FN_SUSPEND = 3'd1;
    localparam logic [2:0] FN_RESUME  = 3'd2;
    localparam logic [2:0] FN_REBOOT  = 3'd3;
    localparam logic [2:0] FN_AUTO    = 3'd4;
    localparam logic [2:0] FN_CORE    = 3'd5;
    localparam logic [2:0] FN_LOCK    = 3'd6;

    // core one actions
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_UP   = 2'd1;
    localparam logic [1:0] ACT_DOWN = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_LOAD_LOW   = 2'd0;
    localparam logic [1:0] REG_LOAD_HIGH  = 2'd1;
    localparam logic [1:0] REG_BASE_DELAY = 2'd2;

    // lock value that stops sampling
    localparam logic [7:0] LOCK_HARD = 8'd1;

    typedef struct packed {
        logic [2:0]           func;
        logic [TIME_BITS-1:0] idle_core0;
        logic [TIME_BITS-1:0] wall_core0;
        logic [TIME_BITS-1:0] idle_core1;
        logic [TIME_BITS-1:0] wall_core1;
        logic [7:0]           setting_value;
    } t_in_item;

    typedef struct packed {
        logic                 core1_online;
        logic [1:0]           core1_action;
        logic                 reschedule;
        logic [15:0]          next_delay;
        logic [LOAD_BITS-1:0] average_load;
        logic                 write_ignored;
    } t_out_item;

    typedef struct packed {
        logic [6:0]  load_low;
        logic [6:0]  load_high;
        logic [13:0] base_delay;
    } t_cfg;

    typedef struct packed {
        logic                 done;
        logic                 bad;
        logic [LOAD_BITS-1:0] load;
    } t_lane_stat;

endpackage
`default_nettype wire

### rtl/chlg_lane.sv
`default_nettype none
module chlg_lane (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [chlg_pkg::TIME_BITS-1:0] i_idle,
    input  wire logic [chlg_pkg::TIME_BITS-1:0] i_wall,
    input  wire logic                          i_commit,
    output chlg_pkg::t_lane_stat               o_stat
);
    import chlg_pkg::*;

    logic [TIME_BITS-1:0]  r_prev_idle;
    logic [TIME_BITS-1:0]  r_prev_wall;
    logic [TIME_BITS-1:0]  r_cur_idle;
    logic [TIME_BITS-1:0]  r_cur_wall;
    logic [DELTA_BITS-1:0] r_di;
    logic [DELTA_BITS-1:0] r_dw;
    logic [NUM_BITS-1:0]   r_rem;
    logic [NUM_BITS-1:0]   r_div;
    logic [LOAD_BITS-1:0]  r_q;
    logic                  r_bad;
    logic                  r_zero;
    logic [CNT_BITS-1:0]   r_cnt;

    logic [TIME_BITS-1:0]  w_didle;
    logic [TIME_BITS-1:0]  w_dwall;
    logic [DELTA_BITS-1:0] w_busy;
    logic [NUM_BITS-1:0]   w_num;
    logic                  w_ge;
    logic [NUM_BITS-1:0]   w_sub;

    // deltas against the stored counters, wrapping at the counter width
    assign w_didle = i_idle - r_prev_idle;
    assign w_dwall = i_wall - r_prev_wall;

    // busy time scaled to percent
    assign w_busy = r_dw - r_di;
    assign w_num  = {{LOAD_BITS{1'b0}}, w_busy} * NUM_BITS'(LOAD_SCALE);

    // one restoring division step
    assign w_ge  = (r_rem >= r_div);
    assign w_sub = r_rem - r_div;

    // stored counters, updated only when the step keeps this core's sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_idle <= '0;
            r_prev_wall <= '0;
        end else if (i_commit) begin
            r_prev_idle <= r_cur_idle;
            r_prev_wall <= r_cur_wall;
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_BITS'(1);
        end else if (r_cnt == CNT_BITS'(LANE_LAST)) begin
            r_cnt <= '0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt + CNT_BITS'(1);
        end
    end

    // datapath: capture, scale, then one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cur_idle <= i_idle;
            r_cur_wall <= i_wall;
            r_di       <= w_didle[DELTA_BITS-1:0];
            r_dw       <= w_dwall[DELTA_BITS-1:0];
        end else if (r_cnt == CNT_BITS'(1)) begin
            r_rem  <= w_num;
            r_div  <= {1'b0, r_dw, {(LOAD_BITS-1){1'b0}}};
            r_q    <= '0;
            r_bad  <= (r_dw < r_di);
            r_zero <= (r_dw == '0);
        end else if (r_cnt != '0) begin
            if (w_ge) begin
                r_rem <= w_sub;
            end
            r_div <= {1'b0, r_div[NUM_BITS-1:1]};
            r_q   <= {r_q[LOAD_BITS-2:0], w_ge};
        end
    end

    assign o_stat.done = (r_cnt == '0);
    assign o_stat.bad  = r_bad;
    assign o_stat.load = r_zero ? '0 : r_q;

endmodule
`default_nettype wire

### rtl/chlg_apb.sv
`default_nettype none
module chlg_apb (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output chlg_pkg::t_cfg   o_cfg
);
    import chlg_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[3:2];

    // register writes, masked to the register width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.load_low   <= 7'd20;
            r_cfg.load_high  <= 7'd60;
            r_cfg.base_delay <= 14'd50;
        end else if (w_wr) begin
            case (w_idx)
                REG_LOAD_LOW:   r_cfg.load_low   <= pwdata[6:0];
                REG_LOAD_HIGH:  r_cfg.load_high  <= pwdata[6:0];
                REG_BASE_DELAY: r_cfg.base_delay <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_idx)
            REG_LOAD_LOW:   prdata = {25'd0, r_cfg.load_low};
            REG_LOAD_HIGH:  prdata = {25'd0, r_cfg.load_high};
            REG_BASE_DELAY: prdata = {18'd0, r_cfg.base_delay};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

### rtl/cpu_hotplug_load_governor.sv
`default_nettype none
// Hotplug governor for the second core. One transaction in gives one transaction out.
// A sample event starts two lanes, one per core, that take the counter deltas and
// divide 100 * busy by wall with a seven-step restoring divider each; a merge stage
// then checks for wall below idle, averages the loads of the online cores and applies
// the thresholds. With the output free, a sample passes from acceptance through the
// scale step and the seven divide steps in the lanes, a sequencer step that sees the
// lanes finish, and the merge and result step, after which the next transaction is
// accepted. Every other event goes from acceptance straight to the result step.
// A finished result sits in an output register, so the next transaction is accepted
// while it waits to be taken.
module cpu_hotplug_load_governor (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire chlg_pkg::t_in_item   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output chlg_pkg::t_out_item       o_out_data,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [3:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready
);
    import chlg_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_RES  = 2'd2;

    logic [1:0]  r_state;
    logic [1:0]  n_state;
    logic [2:0]  r_func;
    logic [7:0]  r_setting;
    logic        r_online;
    logic        n_online;
    logic        r_auto;
    logic        n_auto;
    logic        r_forced;
    logic        n_forced;
    logic [7:0]  r_lock;
    logic [7:0]  n_lock;
    logic [7:0]  r_saved;
    logic [7:0]  n_saved;
    logic [15:0] r_delay;
    logic [15:0] n_delay;
    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   n_out;

    t_cfg        w_cfg;
    t_lane_stat  w_st0;
    t_lane_stat  w_st1;
    logic        w_in_acc;
    logic        w_start;
    logic        w_load_en;
    logic        w_commit0;
    logic        w_commit1;
    logic [7:0]  w_sum;

    // configuration registers
    chlg_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_start    = w_in_acc && (i_in_data.func == FN_SAMPLE);
    assign w_load_en  = (r_state == ST_RES) && (!r_out_valid || !i_out_stall);

    // one lane per core
    chlg_lane u_lane0 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_idle   (i_in_data.idle_core0),
        .i_wall   (i_in_data.wall_core0),
        .i_commit (w_commit0 && w_load_en),
        .o_stat   (w_st0)
    );

    chlg_lane u_lane1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_idle   (i_in_data.idle_core1),
        .i_wall   (i_in_data.wall_core1),
        .i_commit (w_commit1 && w_load_en),
        .o_stat   (w_st1)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_in_data.func == FN_SAMPLE) ? ST_RUN : ST_RES;
                end
            end
            ST_RUN: begin
                if (w_st0.done && w_st1.done) begin
                    n_state = ST_RES;
                end
            end
            ST_RES: begin
                if (w_load_en) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // event fields kept for the merge stage
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_func    <= i_in_data.func;
            r_setting <= i_in_data.setting_value;
        end
    end

    assign w_sum = {1'b0, w_st0.load} + {1'b0, w_st1.load};

    // merge stage and event decisions
    always_comb begin
        logic go;
        go        = 1'b0;
        n_online  = r_online;
        n_auto    = r_auto;
        n_forced  = r_forced;
        n_lock    = r_lock;
        n_saved   = r_saved;
        n_delay   = r_delay;
        w_commit0 = 1'b0;
        w_commit1 = 1'b0;
        n_out     = '0;
        n_out.core1_action = ACT_NONE;
        case (r_func)
            FN_SAMPLE: begin
                if (!r_auto) begin
                    if (!r_forced && r_online) begin
                        n_online = 1'b0;
                        n_out.core1_action = ACT_DOWN;
                    end
                end else begin
                    n_out.reschedule = 1'b1;
                    if (r_lock != LOCK_HARD) begin
                        w_commit0 = 1'b1;
                        if (!w_st0.bad) begin
                            if (r_online) begin
                                w_commit1 = 1'b1;
                                if (!w_st1.bad) begin
                                    n_out.average_load = w_sum[7:1];
                                    go = 1'b1;
                                end
                            end else begin
                                n_out.average_load = w_st0.load;
                                go = 1'b1;
                            end
                        end
                        if (go) begin
                            if ((n_out.average_load < w_cfg.load_low) && r_online) begin
                                n_online = 1'b0;
                                n_out.core1_action = ACT_DOWN;
                                n_delay = {2'b00, w_cfg.base_delay};
                            end else if ((n_out.average_load > w_cfg.load_high)
                                         && !r_online) begin
                                n_online = 1'b1;
                                n_out.core1_action = ACT_UP;
                                n_delay = {w_cfg.base_delay, 2'b00};
                            end
                        end
                    end
                end
            end
            FN_SUSPEND: begin
                n_saved = r_lock;
                n_lock  = LOCK_HARD;
            end
            FN_RESUME: begin
                n_lock = r_saved;
            end
            FN_REBOOT: begin
                n_lock = LOCK_HARD;
            end
            FN_AUTO: begin
                if (r_lock != '0) begin
                    n_out.write_ignored = 1'b1;
                end else if (!r_auto && (r_setting == 8'd1)) begin
                    n_auto  = 1'b1;
                    n_delay = {2'b00, w_cfg.base_delay};
                    n_out.reschedule = 1'b1;
                end else if (r_auto && (r_setting == 8'd0)) begin
                    n_auto   = 1'b0;
                    n_forced = 1'b1;
                    if (!r_online) begin
                        n_online = 1'b1;
                        n_out.core1_action = ACT_UP;
                    end
                end
            end
            FN_CORE: begin
                if (r_auto || (r_lock != '0)) begin
                    n_out.write_ignored = 1'b1;
                end else if (!r_forced && (r_setting == 8'd1)) begin
                    n_forced = 1'b1;
                    if (!r_online) begin
                        n_online = 1'b1;
                        n_out.core1_action = ACT_UP;
                    end
                end else if (r_forced && (r_setting == 8'd0)) begin
                    n_forced = 1'b0;
                    if (r_online) begin
                        n_online = 1'b0;
                        n_out.core1_action = ACT_DOWN;
                    end
                end
            end
            FN_LOCK: begin
                n_lock = r_setting;
            end
            default: ;
        endcase
        n_out.core1_online = n_online;
        n_out.next_delay   = n_out.reschedule ? n_delay : 16'd0;
    end

    // governor state, updated when the result is loaded into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_online <= 1'b1;
            r_auto   <= 1'b1;
            r_forced <= 1'b1;
            r_lock   <= '0;
            r_saved  <= '0;
            r_delay  <= 16'd50;
        end else if (w_load_en) begin
            r_online <= n_online;
            r_auto   <= n_auto;
            r_forced <= n_forced;
            r_lock   <= n_lock;
            r_saved  <= n_saved;
            r_delay  <= n_delay;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_en) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    a_load_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.average_load <= 7'd100))
        else $error("average load above 100");

    a_up_online: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.core1_action == ACT_UP)) |-> o_out_data.core1_online)
        else $error("power up reported with core one offline");

    a_down_offline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.core1_action == ACT_DOWN)) |-> !o_out_data.core1_online)
        else $error("power down reported with core one online");

    a_no_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.reschedule) |-> (o_out_data.next_delay == 16'd0))
        else $error("delay reported without reschedule");

    a_lanes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (!w_st0.done && !w_st1.done && o_in_stall))
        else $error("lanes idle after a sample was accepted");

endmodule
`default_nettype wire

### test/chlg_status_checker.sv
`default_nettype none
module chlg_status_checker (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire chlg_pkg::t_in_item   i_in_data,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire chlg_pkg::t_out_item  i_out_data,
    input  wire logic                 i_psel,
    input  wire logic                 i_penable,
    input  wire logic                 i_pwrite,
    input  wire logic                 i_pready,
    input  wire logic [3:0]           i_paddr,
    input  wire logic [31:0]          i_pwdata,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import chlg_pkg::*;

    // register copy
    logic [6:0]  thr_low;
    logic [6:0]  thr_high;
    logic [13:0] base_ticks;

    // governor state copy
    logic [TIME_BITS-1:0] last_idle [2];
    logic [TIME_BITS-1:0] last_wall [2];
    logic        core1_up;
    logic        auto_on;
    logic        force_up;
    logic [7:0]  lock_now;
    logic [7:0]  lock_saved;
    logic [15:0] delay_now;

    t_out_item expected_status [$];
    t_out_item want;
    int        fails;

    // per core load from counter deltas; 0 when wall delta is below idle delta
    function automatic bit core_busy_pct(input int core, input logic [TIME_BITS-1:0] idle_now,
                                         input logic [TIME_BITS-1:0] wall_now,
                                         output logic [6:0] pct);
        logic [31:0] d_idle;
        logic [31:0] d_wall;
        logic [63:0] scaled;
        d_idle = 32'(idle_now - last_idle[core]);
        d_wall = 32'(wall_now - last_wall[core]);
        last_idle[core] = idle_now;
        last_wall[core] = wall_now;
        pct = '0;
        if (d_wall < d_idle)
            return 1'b0;
        if (d_wall != 0) begin
            scaled = 64'd100 * 64'(d_wall - d_idle);
            pct = 7'(scaled / 64'(d_wall));
        end
        return 1'b1;
    endfunction

    // next status of the governor for one event
    function automatic t_out_item compute_status(input t_in_item ev);
        t_out_item   res;
        logic [6:0]  pct0;
        logic [6:0]  pct1;
        logic [7:0]  sum;
        logic [7:0]  avg;
        int          n;
        bit          ok;
        res = '0;
        case (ev.func)
            FN_SAMPLE: begin
                if (!auto_on) begin
                    if (!force_up && core1_up) begin
                        core1_up = 1'b0;
                        res.core1_action = ACT_DOWN;
                    end
                end else begin
                    res.reschedule = 1'b1;
                    if (lock_now != LOCK_HARD) begin
                        ok = core_busy_pct(0, ev.idle_core0, ev.wall_core0, pct0);
                        sum = 8'(pct0);
                        n = 1;
                        if (ok && core1_up) begin
                            ok = core_busy_pct(1, ev.idle_core1, ev.wall_core1, pct1);
                            sum = sum + 8'(pct1);
                            n = 2;
                        end
                        if (ok) begin
                            avg = sum / 8'(n);
                            res.average_load = 7'(avg);
                            if (avg < 8'(thr_low) && core1_up) begin
                                core1_up = 1'b0;
                                res.core1_action = ACT_DOWN;
                                delay_now = 16'(base_ticks);
                            end else if (avg > 8'(thr_high) && !core1_up) begin
                                core1_up = 1'b1;
                                res.core1_action = ACT_UP;
                                delay_now = {base_ticks, 2'b00};
                            end
                        end
                    end
                end
            end
            FN_SUSPEND: begin
                lock_saved = lock_now;
                lock_now = LOCK_HARD;
            end
            FN_RESUME: lock_now = lock_saved;
            FN_REBOOT: lock_now = LOCK_HARD;
            FN_AUTO: begin
                if (lock_now != 0) begin
                    res.write_ignored = 1'b1;
                end else if (!auto_on && ev.setting_value == 8'd1) begin
                    auto_on = 1'b1;
                    delay_now = 16'(base_ticks);
                    res.reschedule = 1'b1;
                end else if (auto_on && ev.setting_value == 8'd0) begin
                    auto_on = 1'b0;
                    force_up = 1'b1;
                    if (!core1_up) begin
                        core1_up = 1'b1;
                        res.core1_action = ACT_UP;
                    end
                end
            end
            FN_CORE: begin
                if (auto_on || lock_now != 0) begin
                    res.write_ignored = 1'b1;
                end else if (!force_up && ev.setting_value == 8'd1) begin
                    force_up = 1'b1;
                    if (!core1_up) begin
                        core1_up = 1'b1;
                        res.core1_action = ACT_UP;
                    end
                end else if (force_up && ev.setting_value == 8'd0) begin
                    force_up = 1'b0;
                    if (core1_up) begin
                        core1_up = 1'b0;
                        res.core1_action = ACT_DOWN;
                    end
                end
            end
            FN_LOCK: lock_now = ev.setting_value;
            default: ;
        endcase
        res.core1_online = core1_up;
        res.next_delay = res.reschedule ? delay_now : 16'd0;
        return res;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            fails++;
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, exp_val, act_val);
        end
    endtask

    // watch both channels and the register port
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr_low = 7'd20;
            thr_high = 7'd60;
            base_ticks = 14'd50;
            last_idle[0] = '0;
            last_idle[1] = '0;
            last_wall[0] = '0;
            last_wall[1] = '0;
            core1_up = 1'b1;
            auto_on = 1'b1;
            force_up = 1'b1;
            lock_now = '0;
            lock_saved = '0;
            delay_now = 16'd50;
            expected_status.delete();
        end else begin
            // register write
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_LOAD_LOW:   thr_low = i_pwdata[6:0];
                    REG_LOAD_HIGH:  thr_high = i_pwdata[6:0];
                    REG_BASE_DELAY: base_ticks = i_pwdata[13:0];
                    default: ;
                endcase
            end
            // result transaction, compared before this edge's input is predicted
            if (i_out_valid && !i_out_stall) begin
                if (expected_status.size() == 0) begin
                    fails++;
                    $display("%0t ns: result with nothing pending, expected none, actual %h",
                             $time, i_out_data);
                end else begin
                    want = expected_status.pop_front();
                    check_field("core1_online", want.core1_online, i_out_data.core1_online);
                    check_field("core1_action", want.core1_action, i_out_data.core1_action);
                    check_field("reschedule", want.reschedule, i_out_data.reschedule);
                    check_field("next_delay", want.next_delay, i_out_data.next_delay);
                    check_field("average_load", want.average_load, i_out_data.average_load);
                    check_field("write_ignored", want.write_ignored, i_out_data.write_ignored);
                end
            end
            // event transaction
            if (i_in_valid && !i_in_stall)
                expected_status.push_back(compute_status(i_in_data));
        end
        o_pending = expected_status.size();
        o_fail_count = fails;
    end

endmodule
`default_nettype wire

### test/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import chlg_pkg::*;

    localparam logic [2:0] FN_UNUSED   = 3'd7;
    localparam logic [1:0] REG_SPARE   = 2'd3;
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         PHASE_ITEMS = 237;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_stall;
    t_out_item   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    // stimulus side copies of the cumulative counters
    logic [TIME_BITS-1:0] gen_idle [2];
    logic [TIME_BITS-1:0] gen_wall [2];
    int                   sent;
    int                   burst_left;
    int                   taken;
    int                   cycles;

    cpu_hotplug_load_governor DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    chlg_status_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // count result transactions for the long hold
    always @(posedge i_clk)
        if (out_valid && !out_stall)
            taken <= taken + 1;

    // result side stall: short bursts, free stretches, one long hold
    initial begin : result_stall
        int stall_left;
        int free_left;
        int r;
        bit held;
        stall_left = 0;
        free_left = 0;
        held = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && taken >= 400) begin
                held = 1'b1;
                stall_left = 300;
                free_left = 0;
            end
            if (stall_left == 0 && free_left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    free_left = $urandom_range(1, 8);
                else if (r < 55)
                    free_left = $urandom_range(50, 200);
                else if (r < 95)
                    stall_left = $urandom_range(1, 3);
                else
                    stall_left = $urandom_range(15, 60);
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
                free_left--;
            end
        end
    end

    function automatic logic [TIME_BITS-1:0] rand_time();
        return TIME_BITS'({$urandom, $urandom});
    endfunction

    // sample event built from deltas on the running counters
    function automatic t_in_item make_sample(input logic [TIME_BITS-1:0] di0,
                                             input logic [TIME_BITS-1:0] dw0,
                                             input logic [TIME_BITS-1:0] di1,
                                             input logic [TIME_BITS-1:0] dw1);
        t_in_item ev;
        gen_idle[0] = gen_idle[0] + di0;
        gen_wall[0] = gen_wall[0] + dw0;
        gen_idle[1] = gen_idle[1] + di1;
        gen_wall[1] = gen_wall[1] + dw1;
        ev.func = FN_SAMPLE;
        ev.idle_core0 = gen_idle[0];
        ev.wall_core0 = gen_wall[0];
        ev.idle_core1 = gen_idle[1];
        ev.wall_core1 = gen_wall[1];
        ev.setting_value = 8'($urandom);
        return ev;
    endfunction

    function automatic t_in_item make_cmd(input logic [2:0] fn, input logic [7:0] value);
        t_in_item ev;
        ev.func = fn;
        ev.idle_core0 = rand_time();
        ev.wall_core0 = rand_time();
        ev.idle_core1 = rand_time();
        ev.wall_core1 = rand_time();
        ev.setting_value = value;
        return ev;
    endfunction

    // deltas of one core; bias 0 light load, 1 heavy load, else anything
    function automatic void core_deltas(input int bias, output logic [TIME_BITS-1:0] di,
                                        output logic [TIME_BITS-1:0] dw);
        int r;
        int pct;
        r = $urandom_range(0, 99);
        if (r < 3)
            dw = '0;
        else if (r < 88)
            dw = TIME_BITS'($urandom_range(1, 1000000));
        else if (r < 97)
            dw = TIME_BITS'($urandom);
        else
            dw = rand_time();
        case (bias)
            0:       pct = $urandom_range(0, 25);
            1:       pct = $urandom_range(55, 100);
            default: pct = $urandom_range(0, 100);
        endcase
        di = TIME_BITS'((64'(dw) * 64'(pct)) / 64'd100);
        if ($urandom_range(0, 99) < 4)
            di = dw + TIME_BITS'($urandom_range(1, 1000));
    endfunction

    function automatic logic [7:0] mode_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 8'd0;
        if (r < 90)
            return 8'd1;
        return 8'($urandom);
    endfunction

    // mostly well formed events, some noise with every field random
    function automatic t_in_item make_random_event();
        t_in_item             ev;
        logic [TIME_BITS-1:0] di0, dw0, di1, dw1;
        int                   r;
        int                   bias;
        logic [7:0]           lk;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            ev = make_cmd(3'($urandom_range(0, 7)), 8'($urandom));
            return ev;
        end
        r = $urandom_range(0, 99);
        if (r < 58) begin
            bias = $urandom_range(0, 2);
            core_deltas(bias, di0, dw0);
            core_deltas(bias, di1, dw1);
            return make_sample(di0, dw0, di1, dw1);
        end
        if (r < 68) begin
            r = $urandom_range(0, 99);
            lk = (r < 70) ? 8'd0 : (r < 85) ? LOCK_HARD : 8'($urandom);
            return make_cmd(FN_LOCK, lk);
        end
        if (r < 76)
            return make_cmd(FN_AUTO, mode_value());
        if (r < 84)
            return make_cmd(FN_CORE, mode_value());
        if (r < 89)
            return make_cmd(FN_SUSPEND, 8'($urandom));
        if (r < 95)
            return make_cmd(FN_RESUME, 8'($urandom));
        if (r < 98)
            return make_cmd(FN_REBOOT, 8'($urandom));
        return make_cmd(FN_UNUSED, 8'($urandom));
    endfunction

    // offer one event, wait for its transaction, then at times idle a while
    task automatic offer(input t_in_item ev);
        int gap;
        int r;
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data <= ev;
        do @(posedge i_clk); while (in_stall);
        sent++;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 99) < 3)
                burst_left = $urandom_range(20, 60);
            r = $urandom_range(0, 99);
            if (r < 50)
                gap = 0;
            else if (r < 85)
                gap = $urandom_range(1, 3);
            else if (r < 97)
                gap = $urandom_range(4, 10);
            else
                gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic random_events(input int count);
        repeat (count) begin
            offer(make_random_event());
            // one pause mid run until everything is back
            if (sent == 700)
                drain();
        end
    endtask

    task automatic set_thresholds(input int lo, input int hi, input int base);
        drain();
        write_reg(REG_LOAD_LOW, 32'(lo));
        write_reg(REG_LOAD_HIGH, 32'(hi));
        write_reg(REG_BASE_DELAY, 32'(base));
    endtask

    // main stimulus
    initial begin : stimulus
        int lo;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_rst_n = 1'b0;
        sent = 0;
        burst_left = 0;
        gen_idle[0] = '0;
        gen_idle[1] = '0;
        gen_wall[0] = '0;
        gen_wall[1] = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed events at reset thresholds
        offer(make_sample(48'd1000, 48'd1000, 48'd0, 48'd0));      // idle core, zero wall
        offer(make_sample(48'd0, 48'd1000, 48'd5, 48'd5));         // full load, core one off
        offer(make_sample(48'd500, 48'd400, 48'd0, 48'd100));      // core zero wall below idle
        offer(make_sample(48'd0, 48'd100, 48'd200, 48'd100));      // core one wall below idle
        gen_idle[0] = '1;
        gen_idle[1] = '1;
        gen_wall[0] = '1;
        gen_wall[1] = '1;
        offer(make_sample(48'd0, 48'd0, 48'd0, 48'd0));            // counters all ones
        offer(make_sample(48'h20, 48'h100, 48'h20, 48'h100));      // counters wrap past zero
        offer(make_sample(48'h32, 48'h1_0000_0064, 48'd0, 48'hFFFF_FFFF)); // 32 bit truncation
        offer(make_cmd(FN_UNUSED, 8'hFF));
        offer(make_cmd(FN_LOCK, LOCK_HARD));
        offer(make_sample(48'd0, 48'd100, 48'd0, 48'd100));        // locked sample
        offer(make_cmd(FN_AUTO, 8'd0));                            // refused while locked
        offer(make_cmd(FN_LOCK, 8'h80));
        offer(make_sample(48'd90, 48'd100, 48'd90, 48'd100));      // soft lock still samples
        offer(make_cmd(FN_LOCK, 8'd0));
        offer(make_cmd(FN_CORE, 8'd0));                            // refused in auto mode
        offer(make_cmd(FN_AUTO, 8'd2));                            // value out of range
        offer(make_cmd(FN_AUTO, 8'd1));                            // mode already in force
        offer(make_cmd(FN_AUTO, 8'd0));                            // manual mode
        offer(make_sample(48'd0, 48'd100, 48'd0, 48'd100));        // manual sample, forced on
        offer(make_cmd(FN_CORE, 8'd0));
        offer(make_sample(48'd0, 48'd100, 48'd0, 48'd100));        // manual sample, forced off
        offer(make_cmd(FN_CORE, 8'd1));
        offer(make_cmd(FN_AUTO, 8'd1));                            // back to auto
        offer(make_cmd(FN_SUSPEND, 8'd0));
        offer(make_cmd(FN_RESUME, 8'd0));
        offer(make_cmd(FN_REBOOT, 8'd0));
        offer(make_cmd(FN_LOCK, 8'hFF));
        offer(make_cmd(FN_LOCK, 8'd0));

        random_events(PHASE_ITEMS);

        // extremes: nothing crosses the thresholds, longest base
        set_thresholds(0, 100, 16383);
        random_events(PHASE_ITEMS);

        // reversed thresholds toggle core one, shortest base; spare address ignored
        set_thresholds(100, 0, 1);
        write_reg(REG_SPARE, $urandom);
        random_events(PHASE_ITEMS);

        set_thresholds(30, 70, 9000);
        random_events(PHASE_ITEMS);

        lo = $urandom_range(0, 60);
        set_thresholds(lo, $urandom_range(lo, 100), $urandom_range(1, 16383));
        random_events(PHASE_ITEMS);

        set_thresholds(50, 50, 2);
        random_events(PHASE_ITEMS);

        drain();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
rtl/chlg_pkg.sv
rtl/chlg_lane.sv
rtl/chlg_apb.sv
rtl/cpu_hotplug_load_governor.sv
test/chlg_status_checker.sv
test/tb.sv
